[src/rgbc_red_black_classifier_defines.svh]
// Assertion macros for the red/black classifier.
// Included by the top level; the macros expect signals named clock and reset in scope.
`ifndef RGBC_RED_BLACK_CLASSIFIER_DEFINES_SVH
`define RGBC_RED_BLACK_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define RGBC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define RGBC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/rgbc_pkg.sv]
// Shared widths, register indexes, reset values and payload types
// for the red/black classifier. No dependencies.
package rgbc_pkg;

   // Sample and fixed-point widths
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 8;
   localparam int AVG_BITS    = SAMPLE_BITS + FRAC_BITS;
   localparam int WEIGHT_BITS = 10;
   localparam int TENTHS_BITS = 8;
   localparam int MINC_BITS   = 16;

   // Divider sizing: dividend is avg*w + clear, quotient fits the average width
   localparam int NUM_BITS  = AVG_BITS + WEIGHT_BITS;
   localparam int REM_BITS  = WEIGHT_BITS + 1;
   localparam int ITER_BITS = $clog2(AVG_BITS);

   localparam logic [AVG_BITS-1:0] ONE_FIXED = AVG_BITS'(1) << FRAC_BITS;

   // Configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOW_WEIGHT   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FAST_WEIGHT   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RED_RATIO     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLACK_LEVEL   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLACK_SPREAD  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_CLEAR     = 3'd5;

   // Register reset values
   localparam logic [WEIGHT_BITS-1:0] SLOW_WEIGHT_RST   = 10'd300;
   localparam logic [WEIGHT_BITS-1:0] FAST_WEIGHT_RST   = 10'd50;
   localparam logic [TENTHS_BITS-1:0] RED_RATIO_RST     = 8'd14;
   localparam logic [TENTHS_BITS-1:0] BLACK_LEVEL_RST   = 8'd3;
   localparam logic [TENTHS_BITS-1:0] BLACK_SPREAD_RST  = 8'd5;
   localparam logic [MINC_BITS-1:0]   MIN_CLEAR_RST     = 16'd8;

   // Payloads
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] red_raw;
      logic [SAMPLE_BITS-1:0] green_raw;
      logic [SAMPLE_BITS-1:0] blue_raw;
      logic [SAMPLE_BITS-1:0] clear_raw;
      logic                   settled;
   } req_type;

   typedef struct packed {
      logic is_red;
      logic is_black;
   } rsp_type;

endpackage

[src/rgbc_divider.sv]
// Restoring divider, one quotient bit per cycle, for the clear-channel average.
// Depends on rgbc_pkg for widths.
module rgbc_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rgbc_pkg::NUM_BITS-1:0] dividend,
   input  logic [rgbc_pkg::REM_BITS-1:0] divisor,
   output logic [rgbc_pkg::AVG_BITS-1:0] quotient,
   output logic                          done
);

   logic [rgbc_pkg::REM_BITS-1:0]  rem_ff, rem_in;
   logic [rgbc_pkg::AVG_BITS-1:0]  quo_ff, quo_in;
   logic [rgbc_pkg::ITER_BITS-1:0] count_ff, count_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   logic [rgbc_pkg::REM_BITS:0] trial;
   logic [rgbc_pkg::REM_BITS:0] trial_sub;
   logic                        fits;

   // Trial subtract of the divisor from the shifted partial remainder
   assign trial     = {rem_ff, quo_ff[rgbc_pkg::AVG_BITS-1]};
   assign trial_sub = trial - {1'b0, divisor};
   assign fits      = (trial >= {1'b0, divisor});

   // Iteration control; the upper dividend bits are known to be below the
   // divisor, so they seed the remainder and only the low bits iterate
   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = rgbc_pkg::REM_BITS'(dividend[rgbc_pkg::NUM_BITS-1:rgbc_pkg::AVG_BITS]);
         quo_in   = dividend[rgbc_pkg::AVG_BITS-1:0];
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? trial_sub[rgbc_pkg::REM_BITS-1:0] : trial[rgbc_pkg::REM_BITS-1:0];
         quo_in   = {quo_ff[rgbc_pkg::AVG_BITS-2:0], fits};
         count_in = count_ff + rgbc_pkg::ITER_BITS'(1);
         if (count_ff == rgbc_pkg::ITER_BITS'(rgbc_pkg::AVG_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

[src/rgbc_red_black_classifier.sv]
// Red/black classifier top level: registers, sequencer, shared multiplier.
// Depends on rgbc_pkg, rgbc_divider and rgbc_red_black_classifier_defines.svh.
//
//   channel  | direction | handshake            | payload
//   req_     | in        | req_valid / req_stall| rgbc_pkg::req_type
//   rsp_     | out       | rsp_valid / rsp_stall| rgbc_pkg::rsp_type
//   csr_     | in        | csr_valid / csr_ready| csr_index, csr_data
//
// Once the average is loaded, a transaction takes one multiply, 24 divider
// iterations, then four multiplies on the shared multiplier for the ratio checks;
// the first transaction skips the divider and loads the average directly.
// Synchronous reset restores register defaults, unloads the average, stalls req_/csr_.
// A finished result waits in the output register, so a stalled rsp_ side only
// holds the block once the following transaction is ready to deliver.
`include "rgbc_red_black_classifier_defines.svh"

module rgbc_red_black_classifier (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rgbc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rgbc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rgbc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rgbc_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MULW,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_MUL_G,
      ST_MUL_B,
      ST_MUL_S,
      ST_MUL_L,
      ST_CMP_L
   } state_type;

   // Helpers
   function automatic logic [rgbc_pkg::AVG_BITS-1:0] floor_avg(
      input logic [rgbc_pkg::AVG_BITS-1:0] v);
      floor_avg = (v < rgbc_pkg::ONE_FIXED) ? rgbc_pkg::ONE_FIXED : v;
   endfunction

   function automatic logic [rgbc_pkg::SAMPLE_BITS-1:0] abs_diff(
      input logic [rgbc_pkg::SAMPLE_BITS-1:0] a,
      input logic [rgbc_pkg::SAMPLE_BITS-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

   // Times ten as shift and add
   function automatic logic [rgbc_pkg::NUM_BITS-1:0] times_ten(
      input logic [rgbc_pkg::AVG_BITS-1:0] v);
      times_ten = (rgbc_pkg::NUM_BITS'(v) << 3) + (rgbc_pkg::NUM_BITS'(v) << 1);
   endfunction

   state_type state_ff, state_in;

   // Configuration registers
   logic [rgbc_pkg::WEIGHT_BITS-1:0] slow_weight_ff, slow_weight_in;
   logic [rgbc_pkg::WEIGHT_BITS-1:0] fast_weight_ff, fast_weight_in;
   logic [rgbc_pkg::TENTHS_BITS-1:0] red_ratio_ff, red_ratio_in;
   logic [rgbc_pkg::TENTHS_BITS-1:0] black_level_ff, black_level_in;
   logic [rgbc_pkg::TENTHS_BITS-1:0] black_spread_ff, black_spread_in;
   logic [rgbc_pkg::MINC_BITS-1:0]   min_clear_ff, min_clear_in;

   // Running state
   logic [rgbc_pkg::AVG_BITS-1:0] avg_ff, avg_in;
   logic                          loaded_ff, loaded_in;

   // Per-transaction working registers
   rgbc_pkg::req_type                sample_ff, sample_in;
   logic [rgbc_pkg::WEIGHT_BITS-1:0] weight_ff, weight_in;
   logic [rgbc_pkg::SAMPLE_BITS-1:0] diff_ff, diff_in;
   logic [rgbc_pkg::NUM_BITS-1:0]    prod_ff, prod_in;
   logic                             red_ff, red_in;
   logic                             black_ff, black_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   rgbc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Shared multiplier operands
   logic [rgbc_pkg::AVG_BITS-1:0]    mul_a;
   logic [rgbc_pkg::WEIGHT_BITS-1:0] mul_b;
   logic [rgbc_pkg::NUM_BITS-1:0]    mul_product;

   // Derived sample values
   logic [rgbc_pkg::AVG_BITS-1:0]    clear_fixed;
   logic [rgbc_pkg::NUM_BITS-1:0]    red_ten;
   logic [rgbc_pkg::NUM_BITS-1:0]    clear_ten;
   logic [rgbc_pkg::NUM_BITS-1:0]    diff_ten;
   logic [rgbc_pkg::SAMPLE_BITS-1:0] diff_rg, diff_rb, diff_gb, diff_max;
   logic                             clear_over_min;
   logic                             out_free;

   // Divider hookup
   logic                          div_start;
   logic [rgbc_pkg::NUM_BITS-1:0] div_dividend;
   logic [rgbc_pkg::REM_BITS-1:0] div_divisor;
   logic [rgbc_pkg::AVG_BITS-1:0] div_quotient;
   logic                          div_done;

   assign clear_fixed = rgbc_pkg::AVG_BITS'(sample_ff.clear_raw) << rgbc_pkg::FRAC_BITS;
   assign red_ten     = times_ten(rgbc_pkg::AVG_BITS'(sample_ff.red_raw));
   assign clear_ten   = times_ten(clear_fixed);
   assign diff_ten    = times_ten(rgbc_pkg::AVG_BITS'(diff_ff));
   assign mul_product = rgbc_pkg::NUM_BITS'(mul_a) * rgbc_pkg::NUM_BITS'(mul_b);

   assign clear_over_min = rgbc_pkg::NUM_BITS'(sample_ff.clear_raw)
                           > rgbc_pkg::NUM_BITS'(min_clear_ff);

   // Largest pairwise channel difference
   assign diff_rg  = abs_diff(sample_ff.red_raw, sample_ff.green_raw);
   assign diff_rb  = abs_diff(sample_ff.red_raw, sample_ff.blue_raw);
   assign diff_gb  = abs_diff(sample_ff.green_raw, sample_ff.blue_raw);
   assign diff_max = (diff_rg >= diff_rb) ? ((diff_rg >= diff_gb) ? diff_rg : diff_gb)
                                          : ((diff_rb >= diff_gb) ? diff_rb : diff_gb);

   assign div_dividend = prod_ff + rgbc_pkg::NUM_BITS'(clear_fixed);
   assign div_divisor  = rgbc_pkg::REM_BITS'(weight_ff) + rgbc_pkg::REM_BITS'(1);

   rgbc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .done     (div_done)
   );

   // No transaction is taken on either input channel while in reset
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign csr_ready = !reset;

   // Configuration writes
   always_comb begin
      slow_weight_in  = slow_weight_ff;
      fast_weight_in  = fast_weight_ff;
      red_ratio_in    = red_ratio_ff;
      black_level_in  = black_level_ff;
      black_spread_in = black_spread_ff;
      min_clear_in    = min_clear_ff;
      if (csr_valid) begin
         unique case (csr_index)
            rgbc_pkg::CSR_SLOW_WEIGHT:
               slow_weight_in = csr_data[rgbc_pkg::WEIGHT_BITS-1:0];
            rgbc_pkg::CSR_FAST_WEIGHT:
               fast_weight_in = csr_data[rgbc_pkg::WEIGHT_BITS-1:0];
            rgbc_pkg::CSR_RED_RATIO:
               red_ratio_in = csr_data[rgbc_pkg::TENTHS_BITS-1:0];
            rgbc_pkg::CSR_BLACK_LEVEL:
               black_level_in = csr_data[rgbc_pkg::TENTHS_BITS-1:0];
            rgbc_pkg::CSR_BLACK_SPREAD:
               black_spread_in = csr_data[rgbc_pkg::TENTHS_BITS-1:0];
            rgbc_pkg::CSR_MIN_CLEAR:
               min_clear_in = csr_data[rgbc_pkg::MINC_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      avg_in       = avg_ff;
      loaded_in    = loaded_ff;
      sample_in    = sample_ff;
      weight_in    = weight_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      red_in       = red_ff;
      black_in     = black_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_data;
               weight_in = req_data.settled ? slow_weight_ff : fast_weight_ff;
               state_in  = ST_MULW;
            end
         end
         // avg * w; first transaction loads the average directly
         ST_MULW: begin
            mul_a   = avg_ff;
            mul_b   = weight_ff;
            prod_in = mul_product;
            diff_in = diff_max;
            if (loaded_ff) begin
               state_in = ST_DIV_GO;
            end else begin
               avg_in    = floor_avg(clear_fixed);
               loaded_in = 1'b1;
               state_in  = ST_MUL_G;
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               avg_in   = floor_avg(div_quotient);
               state_in = ST_MUL_G;
            end
         end
         ST_MUL_G: begin
            mul_a    = rgbc_pkg::AVG_BITS'(sample_ff.green_raw);
            mul_b    = rgbc_pkg::WEIGHT_BITS'(red_ratio_ff);
            prod_in  = mul_product;
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            red_in   = clear_over_min && (red_ten > prod_ff);
            mul_a    = rgbc_pkg::AVG_BITS'(sample_ff.blue_raw);
            mul_b    = rgbc_pkg::WEIGHT_BITS'(red_ratio_ff);
            prod_in  = mul_product;
            state_in = ST_MUL_S;
         end
         ST_MUL_S: begin
            red_in   = red_ff && (red_ten > prod_ff);
            mul_a    = rgbc_pkg::AVG_BITS'(sample_ff.clear_raw);
            mul_b    = rgbc_pkg::WEIGHT_BITS'(black_spread_ff);
            prod_in  = mul_product;
            state_in = ST_MUL_L;
         end
         ST_MUL_L: begin
            black_in = (sample_ff.clear_raw != '0) && (diff_ten <= prod_ff);
            mul_a    = avg_ff;
            mul_b    = rgbc_pkg::WEIGHT_BITS'(black_level_ff);
            prod_in  = mul_product;
            state_in = ST_CMP_L;
         end
         // Final compare; wait here while the previous result is still held
         ST_CMP_L: begin
            if (out_free) begin
               rsp_data_in.is_red   = red_ff;
               rsp_data_in.is_black = black_ff && (clear_ten < prod_ff);
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      avg_ff      <= avg_in;
      sample_ff   <= sample_in;
      weight_ff   <= weight_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      red_ff      <= red_in;
      black_ff    <= black_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff        <= ST_IDLE;
         loaded_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         slow_weight_ff  <= rgbc_pkg::SLOW_WEIGHT_RST;
         fast_weight_ff  <= rgbc_pkg::FAST_WEIGHT_RST;
         red_ratio_ff    <= rgbc_pkg::RED_RATIO_RST;
         black_level_ff  <= rgbc_pkg::BLACK_LEVEL_RST;
         black_spread_ff <= rgbc_pkg::BLACK_SPREAD_RST;
         min_clear_ff    <= rgbc_pkg::MIN_CLEAR_RST;
      end else begin
         state_ff        <= state_in;
         loaded_ff       <= loaded_in;
         rsp_valid_ff    <= rsp_valid_in;
         slow_weight_ff  <= slow_weight_in;
         fast_weight_ff  <= fast_weight_in;
         red_ratio_ff    <= red_ratio_in;
         black_level_ff  <= black_level_in;
         black_spread_ff <= black_spread_in;
         min_clear_ff    <= min_clear_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   `RGBC_ASSERT_IMP(a_avg_floored, loaded_ff, avg_ff >= rgbc_pkg::ONE_FIXED, "average below 1.0")
   `RGBC_ASSERT_IMP(a_div_done_wait, div_done, state_ff == ST_DIV_WAIT, "divider done out of turn")
   `RGBC_ASSERT_IMP(a_rsp_from_cmp, $rose(rsp_valid_ff), $past(state_ff == ST_CMP_L), "stray result")
   `RGBC_ASSERT_NXT(a_accept_starts, req_valid && !req_stall, state_ff == ST_MULW, "accept lost")

endmodule
